@@ hdl/ctsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared constants for the Cartesian to spherical core: default parameter
// values, working formats of the angle datapath and the arctangent table.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    localparam int DEF_COORD_WIDTH    = 24;
    localparam int DEF_ANGLE_WIDTH    = 16;
    localparam int DEF_ROTATION_STEPS = 18;

    // vector datapath: coordinates sit at binary point WORK_POINT - COORD_WIDTH
    localparam int WORK_WIDTH = 64;
    localparam int WORK_POINT = 60;

    // angle accumulator, 2^31 = pi, with headroom for rounding
    localparam int ACC_WIDTH = 34;

    localparam logic signed [ACC_WIDTH-1:0] QUARTER_TURN = ACC_WIDTH'(2**30);

    // fractional part of the rotation gain, gain = 1 + GAIN_FRACTION / 2^32
    localparam logic [31:0] GAIN_FRACTION = 32'd2777814157;

    localparam int ATAN_ENTRIES = 40;

    // round(atan(2^-i) / pi * 2^31)
    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0
    };

endpackage

@@ hdl/ctsc_point_if.sv @@
// ----------------------------------------------------------------------------
// ctsc_point_if
// Valid/ready channel carrying one Cartesian point.
// ----------------------------------------------------------------------------
interface ctsc_point_if
    import ctsc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

@@ hdl/ctsc_sphere_if.sv @@
// ----------------------------------------------------------------------------
// ctsc_sphere_if
// Valid/ready channel carrying one spherical result.
// ----------------------------------------------------------------------------
interface ctsc_sphere_if
    import ctsc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic        [COORD_WIDTH-1:0] radius;
    logic signed [ANGLE_WIDTH-1:0] elevation;
    logic signed [ANGLE_WIDTH-1:0] azimuth;

    modport source (output valid, output radius, output elevation, output azimuth,
                    input ready);
    modport sink (input valid, input radius, input elevation, input azimuth,
                  output ready);
endinterface

@@ hdl/ctsc_radius.sv @@
// ----------------------------------------------------------------------------
// ctsc_radius
// Rounded Euclidean norm: split-operand squaring, a three-way sum and a
// restoring square root that settles one result bit per stage.
// ----------------------------------------------------------------------------
module ctsc_radius
    import ctsc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    output logic        [COORD_WIDTH-1:0] o_radius
);

    localparam int SUM_WIDTH   = 2 * COORD_WIDTH;
    localparam int TRIAL_WIDTH = SUM_WIDTH + 1;
    localparam int LO_WIDTH    = COORD_WIDTH / 2;
    localparam int HI_WIDTH    = COORD_WIDTH - LO_WIDTH;

    logic [COORD_WIDTH-1:0]  w_coord [3];
    logic [COORD_WIDTH-1:0]  r_mag   [3];
    logic [2*HI_WIDTH-1:0]   r_aa    [3];
    logic [COORD_WIDTH-1:0]  r_ab    [3];
    logic [2*LO_WIDTH-1:0]   r_bb    [3];
    logic [SUM_WIDTH-1:0]    r_sq    [3];
    logic [SUM_WIDTH-1:0]    r_sum;

    logic [SUM_WIDTH-1:0]    w_rem  [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0]  w_root [COORD_WIDTH+1];
    logic [SUM_WIDTH-1:0]    r_rem  [COORD_WIDTH];
    logic [COORD_WIDTH-1:0]  r_root [COORD_WIDTH];

    logic                    w_round_up;
    logic [COORD_WIDTH-1:0]  r_radius;

    assign w_coord[0] = i_x_coord;
    assign w_coord[1] = i_y_coord;
    assign w_coord[2] = i_z_coord;

    for (genvar c = 0; c < 3; c++) begin : g_square
        logic [COORD_WIDTH-1:0] n_mag;
        logic [HI_WIDTH-1:0]    w_hi;
        logic [LO_WIDTH-1:0]    w_lo;

        assign n_mag = w_coord[c][COORD_WIDTH-1] ? (~w_coord[c] + 1'b1) : w_coord[c];
        assign w_hi  = r_mag[c][COORD_WIDTH-1:LO_WIDTH];
        assign w_lo  = r_mag[c][LO_WIDTH-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[c] <= n_mag;
                r_aa[c]  <= {{HI_WIDTH{1'b0}}, w_hi} * {{HI_WIDTH{1'b0}}, w_hi};
                r_ab[c]  <= {{LO_WIDTH{1'b0}}, w_hi} * {{HI_WIDTH{1'b0}}, w_lo};
                r_bb[c]  <= {{LO_WIDTH{1'b0}}, w_lo} * {{LO_WIDTH{1'b0}}, w_lo};
                r_sq[c]  <= (SUM_WIDTH'(r_aa[c]) << (2 * LO_WIDTH))
                          + (SUM_WIDTH'(r_ab[c]) << (LO_WIDTH + 1))
                          + SUM_WIDTH'(r_bb[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign w_rem[0]  = r_sum;
    assign w_root[0] = '0;

    for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_root
        localparam int BIT = COORD_WIDTH - 1 - k;

        logic [TRIAL_WIDTH-1:0] w_trial;
        logic                   w_take;
        logic [SUM_WIDTH-1:0]   n_rem;
        logic [COORD_WIDTH-1:0] n_root;

        always_comb begin
            w_trial = (TRIAL_WIDTH'(w_root[k]) << (BIT + 1))
                    + (TRIAL_WIDTH'(1) << (2 * BIT));
            w_take  = TRIAL_WIDTH'(w_rem[k]) >= w_trial;
            n_rem   = w_take ? (w_rem[k] - w_trial[SUM_WIDTH-1:0]) : w_rem[k];
            n_root  = w_take ? (w_root[k] | (COORD_WIDTH'(1) << BIT)) : w_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end

        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
    end

    // remainder above the root means the true root lies past the half point
    assign w_round_up = w_rem[COORD_WIDTH] > SUM_WIDTH'(w_root[COORD_WIDTH]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= w_root[COORD_WIDTH] + COORD_WIDTH'(w_round_up);
        end
    end

    assign o_radius = r_radius;

endmodule

@@ hdl/ctsc_cordic.sv @@
// ----------------------------------------------------------------------------
// ctsc_cordic
// Vectoring rotator, one micro-rotation per register stage. Drives y toward
// zero and accumulates the angle turned. A side word rides along unchanged.
// ----------------------------------------------------------------------------
module ctsc_cordic
    import ctsc_pkg::*;
#(
    parameter int STEPS      = DEF_ROTATION_STEPS,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [WORK_WIDTH-1:0] i_x,
    input  logic signed [WORK_WIDTH-1:0] i_y,
    input  logic signed [ACC_WIDTH-1:0]  i_ang,
    input  logic        [SIDE_WIDTH-1:0] i_side,
    output logic signed [WORK_WIDTH-1:0] o_x,
    output logic signed [ACC_WIDTH-1:0]  o_ang,
    output logic        [SIDE_WIDTH-1:0] o_side
);

    logic signed [WORK_WIDTH-1:0] w_x    [STEPS+1];
    logic signed [WORK_WIDTH-1:0] w_y    [STEPS+1];
    logic signed [ACC_WIDTH-1:0]  w_ang  [STEPS+1];
    logic        [SIDE_WIDTH-1:0] w_side [STEPS+1];

    logic signed [WORK_WIDTH-1:0] r_x    [STEPS];
    logic signed [WORK_WIDTH-1:0] r_y    [STEPS];
    logic signed [ACC_WIDTH-1:0]  r_ang  [STEPS];
    logic        [SIDE_WIDTH-1:0] r_side [STEPS];

    assign w_x[0]    = i_x;
    assign w_y[0]    = i_y;
    assign w_ang[0]  = i_ang;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic signed [ACC_WIDTH-1:0] STEP_ANGLE =
            $signed(ACC_WIDTH'(ATAN_TABLE[k]));

        logic signed [WORK_WIDTH-1:0] w_dx;
        logic signed [WORK_WIDTH-1:0] w_dy;
        logic signed [WORK_WIDTH-1:0] n_x;
        logic signed [WORK_WIDTH-1:0] n_y;
        logic signed [ACC_WIDTH-1:0]  n_ang;

        always_comb begin
            w_dx = w_y[k] >>> k;
            w_dy = w_x[k] >>> k;
            if (!w_y[k][WORK_WIDTH-1]) begin
                n_x   = w_x[k] + w_dx;
                n_y   = w_y[k] - w_dy;
                n_ang = w_ang[k] + STEP_ANGLE;
            end else begin
                n_x   = w_x[k] - w_dx;
                n_y   = w_y[k] + w_dy;
                n_ang = w_ang[k] - STEP_ANGLE;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_ang[k]  <= n_ang;
                r_side[k] <= w_side[k];
            end
        end

        assign w_x[k+1]    = r_x[k];
        assign w_y[k+1]    = r_y[k];
        assign w_ang[k+1]  = r_ang[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_x    = w_x[STEPS];
    assign o_ang  = w_ang[STEPS];
    assign o_side = w_side[STEPS];

endmodule

@@ hdl/ctsc_angle.sv @@
// ----------------------------------------------------------------------------
// ctsc_angle
// Azimuth and elevation: half-plane fold, gain match of z, two vectoring
// rotators in series and final rounding with the z-axis override.
// ----------------------------------------------------------------------------
module ctsc_angle
    import ctsc_pkg::*;
#(
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH    = DEF_ANGLE_WIDTH,
    parameter int ROTATION_STEPS = DEF_ROTATION_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    output logic signed [ANGLE_WIDTH-1:0] o_elevation,
    output logic signed [ANGLE_WIDTH-1:0] o_azimuth
);

    localparam int WORK_SHIFT  = WORK_POINT - COORD_WIDTH;
    localparam int ROUND_SHIFT = 32 - ANGLE_WIDTH;
    localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
        ACC_WIDTH'((2**ROUND_SHIFT) / 2);
    localparam logic signed [ANGLE_WIDTH-1:0] QUARTER =
        ANGLE_WIDTH'(2**(ANGLE_WIDTH-2));

    typedef struct packed {
        logic on_axis;
        logic z_pos;
        logic z_neg;
    } t_axis_flags;

    typedef struct packed {
        t_axis_flags                  flags;
        logic signed [WORK_WIDTH-1:0] z;
    } t_az_side;

    typedef struct packed {
        t_axis_flags                 flags;
        logic signed [ACC_WIDTH-1:0] az;
    } t_el_side;

    function automatic logic signed [ANGLE_WIDTH-1:0] to_angle(
        input logic signed [ACC_WIDTH-1:0] a
    );
        logic signed [ACC_WIDTH-1:0] t;
        t = (a + ROUND_BIAS) >>> ROUND_SHIFT;
        return t[ANGLE_WIDTH-1:0];
    endfunction

    // fold and flags
    logic signed [WORK_WIDTH-1:0]  w_wx;
    logic signed [WORK_WIDTH-1:0]  w_wy;
    logic        [COORD_WIDTH-1:0] w_zmag;
    logic signed [WORK_WIDTH-1:0]  n_p1_x;
    logic signed [WORK_WIDTH-1:0]  n_p1_y;
    logic signed [ACC_WIDTH-1:0]   n_p1_ang;
    t_axis_flags                   n_p1_flags;

    logic signed [WORK_WIDTH-1:0]  r_p1_x;
    logic signed [WORK_WIDTH-1:0]  r_p1_y;
    logic signed [ACC_WIDTH-1:0]   r_p1_ang;
    logic        [WORK_WIDTH-1:0]  r_p1_mz;
    t_axis_flags                   r_p1_flags;

    logic signed [WORK_WIDTH-1:0]  r_p2_x;
    logic signed [WORK_WIDTH-1:0]  r_p2_y;
    logic signed [ACC_WIDTH-1:0]   r_p2_ang;
    logic        [WORK_WIDTH-1:0]  r_p2_mz;
    logic        [63:0]            r_p2_hi_prod;
    logic        [63:0]            r_p2_lo_prod;
    t_axis_flags                   r_p2_flags;

    logic        [WORK_WIDTH-1:0]  w_mzg;
    t_az_side                      n_p3_side;
    logic signed [WORK_WIDTH-1:0]  r_p3_x;
    logic signed [WORK_WIDTH-1:0]  r_p3_y;
    logic signed [ACC_WIDTH-1:0]   r_p3_ang;
    t_az_side                      r_p3_side;

    logic signed [WORK_WIDTH-1:0]  w_az_x;
    logic signed [ACC_WIDTH-1:0]   w_az_ang;
    logic        [$bits(t_az_side)-1:0] w_az_side_bits;
    t_az_side                      w_az_side;
    t_el_side                      w_el_in_side;

    logic signed [ACC_WIDTH-1:0]   w_el_ang;
    logic        [$bits(t_el_side)-1:0] w_el_side_bits;
    t_el_side                      w_el_side;
    logic signed [WORK_WIDTH-1:0]  w_el_x;

    logic signed [ANGLE_WIDTH-1:0] n_elevation;
    logic signed [ANGLE_WIDTH-1:0] n_azimuth;
    logic signed [ANGLE_WIDTH-1:0] r_elevation;
    logic signed [ANGLE_WIDTH-1:0] r_azimuth;

    always_comb begin
        w_wx   = WORK_WIDTH'(i_x_coord) <<< WORK_SHIFT;
        w_wy   = WORK_WIDTH'(i_y_coord) <<< WORK_SHIFT;
        w_zmag = i_z_coord[COORD_WIDTH-1] ? (~i_z_coord + 1'b1) : i_z_coord;
        n_p1_x   = w_wx;
        n_p1_y   = w_wy;
        n_p1_ang = '0;
        // turn the left half plane by a quarter turn toward +x
        if (w_wx[WORK_WIDTH-1]) begin
            if (!w_wy[WORK_WIDTH-1]) begin
                n_p1_x   = w_wy;
                n_p1_y   = -w_wx;
                n_p1_ang = QUARTER_TURN;
            end else begin
                n_p1_x   = -w_wy;
                n_p1_y   = w_wx;
                n_p1_ang = -QUARTER_TURN;
            end
        end
        n_p1_flags.on_axis = (i_x_coord == '0) && (i_y_coord == '0);
        n_p1_flags.z_neg   = i_z_coord[COORD_WIDTH-1];
        n_p1_flags.z_pos   = !i_z_coord[COORD_WIDTH-1] && (i_z_coord != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_x     <= n_p1_x;
            r_p1_y     <= n_p1_y;
            r_p1_ang   <= n_p1_ang;
            r_p1_mz    <= WORK_WIDTH'(w_zmag) << WORK_SHIFT;
            r_p1_flags <= n_p1_flags;
        end
    end

    // gain match of |z|, split into two 32-bit products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_x       <= r_p1_x;
            r_p2_y       <= r_p1_y;
            r_p2_ang     <= r_p1_ang;
            r_p2_mz      <= r_p1_mz;
            r_p2_hi_prod <= {32'd0, r_p1_mz[WORK_WIDTH-1:32]} * {32'd0, GAIN_FRACTION};
            r_p2_lo_prod <= {32'd0, r_p1_mz[31:0]} * {32'd0, GAIN_FRACTION};
            r_p2_flags   <= r_p1_flags;
        end
    end

    always_comb begin
        w_mzg = r_p2_mz + r_p2_hi_prod + (r_p2_lo_prod >> 32);
        n_p3_side.flags = r_p2_flags;
        n_p3_side.z     = r_p2_flags.z_neg ? -$signed(w_mzg) : $signed(w_mzg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3_x    <= r_p2_x;
            r_p3_y    <= r_p2_y;
            r_p3_ang  <= r_p2_ang;
            r_p3_side <= n_p3_side;
        end
    end

    ctsc_cordic #(
        .STEPS      (ROTATION_STEPS),
        .SIDE_WIDTH ($bits(t_az_side))
    ) u_azimuth (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r_p3_x),
        .i_y    (r_p3_y),
        .i_ang  (r_p3_ang),
        .i_side (r_p3_side),
        .o_x    (w_az_x),
        .o_ang  (w_az_ang),
        .o_side (w_az_side_bits)
    );

    assign w_az_side          = w_az_side_bits;
    assign w_el_in_side.flags = w_az_side.flags;
    assign w_el_in_side.az    = w_az_ang;

    ctsc_cordic #(
        .STEPS      (ROTATION_STEPS),
        .SIDE_WIDTH ($bits(t_el_side))
    ) u_elevation (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (w_az_x),
        .i_y    (w_az_side.z),
        .i_ang  ('0),
        .i_side (w_el_in_side),
        .o_x    (w_el_x),
        .o_ang  (w_el_ang),
        .o_side (w_el_side_bits)
    );

    assign w_el_side = w_el_side_bits;

    always_comb begin
        n_elevation = to_angle(w_el_ang);
        n_azimuth   = to_angle(w_el_side.az);
        if (w_el_side.flags.on_axis) begin
            n_azimuth = '0;
            if (w_el_side.flags.z_pos) begin
                n_elevation = QUARTER;
            end else if (w_el_side.flags.z_neg) begin
                n_elevation = -QUARTER;
            end else begin
                n_elevation = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elevation <= n_elevation;
            r_azimuth   <= n_azimuth;
        end
    end

    assign o_elevation = r_elevation;
    assign o_azimuth   = r_azimuth;

endmodule

@@ hdl/ctsc_out_buf.sv @@
// ----------------------------------------------------------------------------
// ctsc_out_buf
// Two-entry output buffer: an output register plus a skid register. The
// upstream ready is registered and drops only once the skid entry fills.
// ----------------------------------------------------------------------------
module ctsc_out_buf
    import ctsc_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_COORD_WIDTH + 2 * DEF_ANGLE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    input  logic                  i_ready
);

    logic                  r_out_valid;
    logic                  r_skid_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic [DATA_WIDTH-1:0] r_skid_data;

    logic                  n_out_valid;
    logic                  n_skid_valid;
    logic                  w_take;
    logic                  w_load_out;
    logic                  w_load_skid;
    logic                  w_out_from_skid;

    always_comb begin
        w_take          = r_out_valid && i_ready;
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (r_skid_valid) begin
            if (w_take) begin
                n_skid_valid    = 1'b0;
                w_out_from_skid = 1'b1;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                w_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out_data <= r_skid_data;
        end else if (w_load_out) begin
            r_out_data <= i_data;
        end
        if (w_load_skid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready && !r_skid_valid && i_valid |=> r_skid_valid)
        else $error("transfer during output stall not parked in skid");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> !r_skid_valid && r_out_valid)
        else $error("skid entry not moved to output after transfer");

endmodule

@@ hdl/cartesian_to_spherical_core.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a signed Cartesian point to radius, elevation and azimuth.
//
// Input channel i_point carries x_coord, y_coord, z_coord; output channel
// o_sphere carries radius (rounded norm, input units), elevation and azimuth
// (binary angles, 2^(ANGLE_WIDTH-1) = pi). Both are valid/ready channels.
// Throughput: one point per cycle while the receiver keeps taking results.
// The longer of two paths sets the pipeline depth: the square root settles one
// radius bit per stage, the angle rotators spend one stage per micro-rotation
// (azimuth, then elevation). The shorter path is padded with delay stages.
// Reset clears the valid bits of the pipeline and the output buffer; no
// result is presented until a point has been taken after reset.
// When the receiver stalls, the result stays on o_sphere and the next one is
// parked in a skid register; the pipeline then freezes and i_point.ready
// drops until the receiver takes a result. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core
    import ctsc_pkg::*;
#(
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH    = DEF_ANGLE_WIDTH,
    parameter int ROTATION_STEPS = DEF_ROTATION_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctsc_point_if.sink    i_point,
    ctsc_sphere_if.source o_sphere
);

    localparam int RADIUS_LATENCY = COORD_WIDTH + 5;
    localparam int ANGLE_LATENCY  = 2 * ROTATION_STEPS + 4;
    localparam int PIPE_LATENCY   = (RADIUS_LATENCY > ANGLE_LATENCY) ?
                                    RADIUS_LATENCY : ANGLE_LATENCY;
    localparam int RADIUS_PAD     = PIPE_LATENCY - RADIUS_LATENCY;
    localparam int ANGLE_PAD      = PIPE_LATENCY - ANGLE_LATENCY;
    localparam int DATA_WIDTH     = COORD_WIDTH + 2 * ANGLE_WIDTH;

    logic                          w_advance;
    logic [PIPE_LATENCY-1:0]       r_valid;
    logic [PIPE_LATENCY-1:0]       n_valid;

    logic        [COORD_WIDTH-1:0] w_radius;
    logic signed [ANGLE_WIDTH-1:0] w_elevation;
    logic signed [ANGLE_WIDTH-1:0] w_azimuth;
    logic        [COORD_WIDTH-1:0] w_radius_end;
    logic signed [ANGLE_WIDTH-1:0] w_elevation_end;
    logic signed [ANGLE_WIDTH-1:0] w_azimuth_end;

    logic [DATA_WIDTH-1:0]         w_result;
    logic [DATA_WIDTH-1:0]         w_out_data;

    assign i_point.ready = w_advance;

    // valid bits advance in step with the datapath stages
    assign n_valid = {r_valid[PIPE_LATENCY-2:0], i_point.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_advance) begin
            r_valid <= n_valid;
        end
    end

    ctsc_radius #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_radius (
        .i_clk     (i_clk),
        .i_en      (w_advance),
        .i_x_coord (i_point.x_coord),
        .i_y_coord (i_point.y_coord),
        .i_z_coord (i_point.z_coord),
        .o_radius  (w_radius)
    );

    ctsc_angle #(
        .COORD_WIDTH    (COORD_WIDTH),
        .ANGLE_WIDTH    (ANGLE_WIDTH),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_angle (
        .i_clk       (i_clk),
        .i_en        (w_advance),
        .i_x_coord   (i_point.x_coord),
        .i_y_coord   (i_point.y_coord),
        .i_z_coord   (i_point.z_coord),
        .o_elevation (w_elevation),
        .o_azimuth   (w_azimuth)
    );

    if (RADIUS_PAD > 0) begin : g_radius_pad
        logic [COORD_WIDTH-1:0] r_radius_pad [RADIUS_PAD];

        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_radius_pad[0] <= w_radius;
                for (int i = 1; i < RADIUS_PAD; i++) begin
                    r_radius_pad[i] <= r_radius_pad[i-1];
                end
            end
        end

        assign w_radius_end = r_radius_pad[RADIUS_PAD-1];
    end else begin : g_radius_direct
        assign w_radius_end = w_radius;
    end

    if (ANGLE_PAD > 0) begin : g_angle_pad
        logic signed [ANGLE_WIDTH-1:0] r_elevation_pad [ANGLE_PAD];
        logic signed [ANGLE_WIDTH-1:0] r_azimuth_pad   [ANGLE_PAD];

        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_elevation_pad[0] <= w_elevation;
                r_azimuth_pad[0]   <= w_azimuth;
                for (int i = 1; i < ANGLE_PAD; i++) begin
                    r_elevation_pad[i] <= r_elevation_pad[i-1];
                    r_azimuth_pad[i]   <= r_azimuth_pad[i-1];
                end
            end
        end

        assign w_elevation_end = r_elevation_pad[ANGLE_PAD-1];
        assign w_azimuth_end   = r_azimuth_pad[ANGLE_PAD-1];
    end else begin : g_angle_direct
        assign w_elevation_end = w_elevation;
        assign w_azimuth_end   = w_azimuth;
    end

    assign w_result = {w_radius_end, w_elevation_end, w_azimuth_end};

    ctsc_out_buf #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid[PIPE_LATENCY-1]),
        .i_data  (w_result),
        .o_ready (w_advance),
        .o_valid (o_sphere.valid),
        .o_data  (w_out_data),
        .i_ready (o_sphere.ready)
    );

    assign o_sphere.radius    = w_out_data[DATA_WIDTH-1 -: COORD_WIDTH];
    assign o_sphere.elevation = w_out_data[2*ANGLE_WIDTH-1 -: ANGLE_WIDTH];
    assign o_sphere.azimuth   = w_out_data[ANGLE_WIDTH-1:0];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("pipeline valid bits not cleared by reset");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_valid))
        else $error("pipeline moved while frozen");

    a_end_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[PIPE_LATENCY-1] && w_advance |=> o_sphere.valid)
        else $error("finished result not presented at output");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cartesian_to_spherical_core. Points go in through a
// valid/ready driver fed from a queue; every transferred point is converted
// by a bit-exact predictor (exact rounded norm, two CORDIC vectoring passes
// for the angles) and the results are checked field by field, in order.
// Directed corner points come first, then random points under several
// idle/stall mixes, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW         = ctsc_pkg::DEF_COORD_WIDTH;
    localparam int AW         = ctsc_pkg::DEF_ANGLE_WIDTH;
    localparam int STEPS      = ctsc_pkg::DEF_ROTATION_STEPS;
    localparam int WORK_SHIFT = 60 - CW;
    localparam int ANG_SHIFT  = 32 - AW;
    localparam int LUT_DEPTH  = 40;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;

    localparam int COORD_MAX = 2**(CW-1) - 1;
    localparam int COORD_MIN = -(2**(CW-1));

    localparam bit [63:0] ROT_GAIN_FRAC = 64'd2777814157;

    // atan(2^-i) in units of pi / 2^31
    localparam longint ARCTAN_LUT [LUT_DEPTH] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_point;

    typedef struct {
        logic        [CW-1:0] radius;
        logic signed [AW-1:0] elevation;
        logic signed [AW-1:0] azimuth;
    } t_sphere;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctsc_point_if #(.COORD_WIDTH(CW)) pt_if ();
    ctsc_sphere_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) sp_if ();

    cartesian_to_spherical_core #(
        .COORD_WIDTH   (CW),
        .ANGLE_WIDTH   (AW),
        .ROTATION_STEPS(STEPS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (pt_if),
        .o_sphere(sp_if)
    );

    t_point  point_q[$];
    t_sphere sphere_q[$];
    t_sphere due_sphere;

    int mismatch_count = 0;
    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;
    int hold_len       = 0;
    int hold_tag       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    bit in_taken       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void rotate_to_axis(inout longint vx, inout longint vy,
                                           inout longint ang);
        longint dx;
        longint dy;
        for (int i = 0; i < STEPS && i < LUT_DEPTH; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx;
                vy -= dy;
                ang += ARCTAN_LUT[i];
            end else begin
                vx -= dx;
                vy += dy;
                ang -= ARCTAN_LUT[i];
            end
        end
    endfunction

    function automatic logic signed [AW-1:0] binary_angle(longint acc);
        longint r;
        r = (acc + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
        return r[AW-1:0];
    endfunction

    function automatic t_sphere predict_sphere(t_point p);
        longint    px;
        longint    py;
        longint    pz;
        longint    vx;
        longint    vy;
        longint    vz;
        longint    turn;
        longint    az_acc;
        longint    el_acc;
        longint    scale;
        bit [63:0] sq;
        bit [63:0] root;
        bit [63:0] cand;
        bit [63:0] mz;
        t_sphere   res;
        px = longint'(p.x);
        py = longint'(p.y);
        pz = longint'(p.z);

        sq = px * px + py * py + pz * pz;
        root = '0;
        for (int b = CW + 1; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= sq)
                root = cand;
        end
        if (sq > root * root + root)
            root++;
        res.radius = root[CW-1:0];

        // on the z axis: straight up or down (zero at the origin), no azimuth
        if (px == 0 && py == 0) begin
            el_acc = pz > 0 ? (longint'(1) << (AW - 2)) :
                     pz < 0 ? -(longint'(1) << (AW - 2)) : 0;
            res.elevation = el_acc[AW-1:0];
            res.azimuth   = '0;
            return res;
        end

        scale  = longint'(1) << WORK_SHIFT;
        vx     = px * scale;
        vy     = py * scale;
        az_acc = 0;
        el_acc = 0;
        // turn a left half plane vector a quarter turn toward +x
        if (vx < 0) begin
            turn = vx;
            if (vy >= 0) begin
                vx = vy;
                vy = -turn;
                az_acc = longint'(1) << 30;
            end else begin
                vx = -vy;
                vy = turn;
                az_acc = -(longint'(1) << 30);
            end
        end
        rotate_to_axis(vx, vy, az_acc);

        // scale z by the gain already carried by the xy hypotenuse
        mz = pz < 0 ? -(pz * scale) : pz * scale;
        mz = mz + (mz >> 32) * ROT_GAIN_FRAC
                + (((mz & 64'hFFFF_FFFF) * ROT_GAIN_FRAC) >> 32);
        vz = pz < 0 ? -longint'(mz) : longint'(mz);
        rotate_to_axis(vx, vz, el_acc);

        res.elevation = binary_angle(el_acc);
        res.azimuth   = binary_angle(az_acc);
        return res;
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = int'($urandom_range(0, 128)) - 64;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = COORD_MAX;
                    1: v = COORD_MIN;
                    2: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom());
        endcase
        return v[CW-1:0];
    endfunction

    task automatic add_point(int x, int y, int z);
        t_point p;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.z = z[CW-1:0];
        point_q.push_back(p);
    endtask

    task automatic add_random_points(int count);
        t_point p;
        repeat (count) begin
            p.x = random_coord();
            p.y = random_coord();
            p.z = random_coord();
            if ($urandom_range(0, 19) == 0) begin
                p.x = '0;
                p.y = '0;
            end
            point_q.push_back(p);
        end
    endtask

    task automatic wait_drained();
        while (point_q.size() != 0 || sphere_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic convert_phase(int idle_pct, int stall_pct, int count);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        add_random_points(count);
        wait_drained();
    endtask

    // driver: present the queue head, hold it until the transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || in_taken) begin
            if (point_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                pt_if.valid   <= 1'b1;
                pt_if.x_coord <= point_q[0].x;
                pt_if.y_coord <= point_q[0].y;
                pt_if.z_coord <= point_q[0].z;
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sp_if.ready <= 1'b0;
        end else if (hold_tag != hold_seen) begin
            hold_seen   <= hold_tag;
            hold_left   <= hold_len;
            sp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            sp_if.ready <= 1'b0;
        end else begin
            sp_if.ready <= $urandom_range(0, 99) >= snk_stall_pct;
        end
    end

    // input transfer: predict, then advance the queue
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && pt_if.valid && pt_if.ready;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            sphere_q.push_back(predict_sphere('{pt_if.x_coord, pt_if.y_coord,
                                                pt_if.z_coord}));
            void'(point_q.pop_front());
        end
    end

    // output transfer: check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && sp_if.valid && sp_if.ready) begin
            if (sphere_q.size() == 0) begin
                $display("%0t: unexpected result radius %0d elevation %0d azimuth %0d",
                         $time, sp_if.radius, sp_if.elevation, sp_if.azimuth);
                mismatch_count++;
            end else begin
                due_sphere = sphere_q.pop_front();
                if (sp_if.radius !== due_sphere.radius) begin
                    $display("%0t: radius expected %0d actual %0d",
                             $time, due_sphere.radius, sp_if.radius);
                    mismatch_count++;
                end
                if (sp_if.elevation !== due_sphere.elevation) begin
                    $display("%0t: elevation expected %0d actual %0d",
                             $time, due_sphere.elevation, sp_if.elevation);
                    mismatch_count++;
                end
                if (sp_if.azimuth !== due_sphere.azimuth) begin
                    $display("%0t: azimuth expected %0d actual %0d",
                             $time, due_sphere.azimuth, sp_if.azimuth);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (sp_if.valid && sp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        pt_if.valid   = 1'b0;
        pt_if.x_coord = '0;
        pt_if.y_coord = '0;
        pt_if.z_coord = '0;
        sp_if.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_point(0, 0, 0);
        add_point(0, 0, COORD_MAX);
        add_point(0, 0, COORD_MIN);
        add_point(COORD_MAX, 0, 0);
        add_point(COORD_MIN, 0, 0);
        add_point(0, COORD_MAX, 0);
        add_point(0, COORD_MIN, 0);
        add_point(COORD_MAX, COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN);
        add_point(COORD_MIN, COORD_MAX, COORD_MIN);
        add_point(COORD_MAX, COORD_MIN, COORD_MAX);
        add_point(COORD_MIN, -1, COORD_MAX);
        add_point(COORD_MIN, 1, 1);
        add_point(-1, 0, 0);
        add_point(-7, 0, 5);
        add_point(-1, 1, 0);
        add_point(-1, -1, -1);
        add_point(1, 0, 0);
        add_point(1, 1, 1);
        add_point(0, -1, 1);
        add_point(-100, 5, -7);
        add_point(-3, -200, 40);
        add_point(5000, -1, 0);
        wait_drained();

        convert_phase(0, 0, PHASE_ITEMS);
        convert_phase(54, 0, PHASE_ITEMS);
        convert_phase(0, 54, PHASE_ITEMS);
        convert_phase(19, 19, PHASE_ITEMS);

        // fill the pipeline against a held receiver
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        add_random_points(PHASE_ITEMS + 30);
        hold_len = HOLD_CYCLES;
        hold_tag++;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
